// File: src/huffman_tree_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// huffman tree decoder assertion macros
// shared assertion forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HTDU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// types, codes and sizes shared by the huffman tree decoder modules
// ----------------------------------------------------------------------------
package htd_pkg;

  // node store geometry
  localparam int NODE_COUNT   = 512;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int FREE_W       = NODE_W + 1;
  localparam int MAX_CODE_LEN = 32;

  // field widths
  localparam int CODE_W  = 32;
  localparam int CIDX_W  = $clog2(CODE_W);
  localparam int LEN_W   = 6;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int BIDX_W  = $clog2(BYTE_W);
  localparam int CNT_W   = 32;
  localparam int BITS_W  = 35;
  localparam logic [BITS_W-1:0] BITS_MAX = {BITS_W{1'b1}};

  // request kinds
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_DECODE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_SYMBOL  = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADLEN  = 2'd3;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 35;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SYMBOLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS    = 1'b1;

  typedef logic [NODE_W-1:0] node_idx_t;

  // one node store entry
  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    node_idx_t         left;
    node_idx_t         right;
  } node_t;

  // controller to datapath commands
  typedef struct packed {
    logic       cap_load;
    logic       cap_dec;
    logic       clear;
    logic       ld_read;
    logic       ld_take;
    logic       ld_link;
    logic       ld_new;
    logic       ld_leaf;
    logic       err_res;
    logic [1:0] err_status;
    logic       dc_fetch;
    logic       dc_load_cur;
    logic       dc_step;
    logic       dc_land;
    logic       flush;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic len_bad;
    logic at_root;
    logic ld_done;
    logic ld_kid_zero;
    logic store_full;
    logic stop;
    logic dc_kid_zero;
    logic bit_last;
    logic pend_v;
    logic pend_ok;
    logic out_free;
  } sts_t;

endpackage

// File: src/htd_ctrl.sv
// ----------------------------------------------------------------------------
// htd_ctrl
// sequencer for load, decode and clear requests of the tree decoder
// ----------------------------------------------------------------------------
module htd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic [1:0]     in_req_type,
  output logic           in_tready,
  output htd_pkg::cmd_t  cmd,
  input  htd_pkg::sts_t  sts
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LD_WALK  = 8'b0000_0010,
    S_LD_WAIT  = 8'b0000_0100,
    S_LD_NEW   = 8'b0000_1000,
    S_DC_FETCH = 8'b0001_0000,
    S_DC_BIT   = 8'b0010_0000,
    S_DC_LAND  = 8'b0100_0000,
    S_FLUSH    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_req_type)
            htd_pkg::REQ_LOAD: begin
              if (sts.len_bad) begin
                cmd.err_res    = 1'b1;
                cmd.err_status = htd_pkg::ST_BADLEN;
                state_nxt      = S_FLUSH;
              end else begin
                cmd.cap_load = 1'b1;
                state_nxt    = S_LD_WALK;
              end
            end
            htd_pkg::REQ_DECODE: begin
              cmd.cap_dec = 1'b1;
              if (sts.at_root) begin
                state_nxt = S_DC_BIT;
              end else begin
                cmd.dc_fetch = 1'b1;
                state_nxt    = S_DC_FETCH;
              end
            end
            htd_pkg::REQ_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
              // unknown request is dropped
            end
          endcase
        end
      end
      S_LD_WALK: begin
        if (sts.ld_done) begin
          cmd.ld_leaf = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.ld_kid_zero) begin
          cmd.ld_read = 1'b1;
          state_nxt   = S_LD_WAIT;
        end else if (sts.store_full) begin
          cmd.err_res    = 1'b1;
          cmd.err_status = htd_pkg::ST_FULL;
          state_nxt      = S_FLUSH;
        end else begin
          cmd.ld_link = 1'b1;
          state_nxt   = S_LD_NEW;
        end
      end
      S_LD_WAIT: begin
        cmd.ld_take = 1'b1;
        state_nxt   = S_LD_WALK;
      end
      S_LD_NEW: begin
        cmd.ld_new = 1'b1;
        state_nxt  = S_LD_WALK;
      end
      S_DC_FETCH: begin
        cmd.dc_load_cur = 1'b1;
        state_nxt       = S_DC_BIT;
      end
      S_DC_BIT: begin
        if (sts.stop) begin
          state_nxt = S_FLUSH;
        end else if (sts.pend_ok) begin
          cmd.dc_step = 1'b1;
          if (!sts.dc_kid_zero) begin
            state_nxt = S_DC_LAND;
          end else if (sts.bit_last) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_DC_LAND: begin
        if (sts.pend_ok) begin
          cmd.dc_land = 1'b1;
          state_nxt   = sts.bit_last ? S_FLUSH : S_DC_BIT;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_v || sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/htd_datapath.sv
// ----------------------------------------------------------------------------
// htd_datapath
// node store, walk registers, counters and result staging of the decoder
// ----------------------------------------------------------------------------
`include "huffman_tree_decoder_unit_assert.svh"

module htd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  htd_pkg::cmd_t                    cmd,
  output htd_pkg::sts_t                    sts,
  input  logic [htd_pkg::CODE_W-1:0]       in_code,
  input  logic [htd_pkg::LEN_W-1:0]        in_code_length,
  input  logic [htd_pkg::SYM_W-1:0]        in_symbol,
  input  logic [htd_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                             cfg_we,
  input  logic [htd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_tready,
  output logic                             out_valid,
  output logic [htd_pkg::SYM_W-1:0]        out_symbol,
  output logic [1:0]                       out_status,
  output logic                             out_last,
  output logic                             out_done
);

  // node store, entry 0 unused (root lives in flops)
  htd_pkg::node_t mem [htd_pkg::NODE_COUNT];
  htd_pkg::node_t rd_r;

  htd_pkg::node_idx_t root_left_r, root_right_r;
  htd_pkg::node_t     cur_r;
  htd_pkg::node_idx_t walk_r, cur_node_r, kid_r;
  logic [htd_pkg::LEN_W-1:0]   len_r;
  logic [htd_pkg::CODE_W-1:0]  code_r;
  logic [htd_pkg::SYM_W-1:0]   sym_r;
  logic [htd_pkg::BYTE_W-1:0]  byte_r;
  logic [htd_pkg::BIDX_W-1:0]  bit_r;
  logic [htd_pkg::FREE_W-1:0]  next_free_r;
  logic [htd_pkg::CNT_W-1:0]   decoded_r, tot_sym_r;
  logic [htd_pkg::BITS_W-1:0]  bits_r, tot_bits_r;

  logic                        pend_v_r, pend_done_r;
  logic [htd_pkg::SYM_W-1:0]   pend_sym_r;
  logic [1:0]                  pend_st_r;
  logic                        out_valid_r, out_last_r, out_done_r;
  logic [htd_pkg::SYM_W-1:0]   out_sym_r;
  logic [1:0]                  out_st_r;

  htd_pkg::node_t     root_node, link_node;
  htd_pkg::node_idx_t ld_kid, dc_kid, new_idx;
  logic [htd_pkg::LEN_W-1:0]  len_dec;
  logic [htd_pkg::CIDX_W-1:0] code_idx;
  logic                       ld_dir, dc_dir, land_leaf;
  logic                       mem_we, mem_re;
  htd_pkg::node_idx_t         mem_wa, mem_ra;
  htd_pkg::node_t             mem_wd;
  logic                       res_en, res_done, push, out_free;
  logic [htd_pkg::SYM_W-1:0]  res_sym;
  logic [1:0]                 res_st;
  logic [htd_pkg::CNT_W-1:0]  decoded_nxt;

  // child selection for the load walk and the decode walk
  assign root_node = '{leaf: 1'b0, sym: '0, left: root_left_r, right: root_right_r};
  assign len_dec   = len_r - htd_pkg::LEN_W'(1);
  assign code_idx  = len_dec[htd_pkg::CIDX_W-1:0];
  assign ld_dir    = code_r[code_idx];
  assign ld_kid    = ld_dir ? cur_r.right : cur_r.left;
  assign dc_dir    = byte_r[bit_r];
  assign dc_kid    = dc_dir ? cur_r.right : cur_r.left;
  assign new_idx   = next_free_r[htd_pkg::NODE_W-1:0];
  assign land_leaf = rd_r.leaf;

  // parent entry with the new child hooked in
  always_comb begin
    link_node = cur_r;
    if (ld_dir) begin
      link_node.right = new_idx;
    end else begin
      link_node.left = new_idx;
    end
  end

  // node store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = walk_r;
    mem_wd = link_node;
    if (cmd.ld_link && (walk_r != '0)) begin
      mem_we = 1'b1;
    end else if (cmd.ld_new) begin
      mem_we = 1'b1;
      mem_wa = new_idx;
      mem_wd = '0;
    end else if (cmd.ld_leaf) begin
      mem_we = 1'b1;
      mem_wd = '{leaf: 1'b1, sym: sym_r, left: cur_r.left, right: cur_r.right};
    end
    mem_re = cmd.ld_read || cmd.dc_fetch || (cmd.dc_step && (dc_kid != '0));
    mem_ra = cmd.dc_fetch ? cur_node_r : (cmd.ld_read ? ld_kid : dc_kid);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  // results produced this cycle
  assign decoded_nxt = decoded_r +
                       htd_pkg::CNT_W'(cmd.dc_land && land_leaf);
  assign res_en   = cmd.err_res || (cmd.dc_step && (dc_kid == '0)) ||
                    (cmd.dc_land && land_leaf);
  assign res_sym  = cmd.dc_land ? rd_r.sym : '0;
  assign res_st   = cmd.err_res ? cmd.err_status :
                    (cmd.dc_land ? htd_pkg::ST_SYMBOL : htd_pkg::ST_MISSING);
  assign res_done = (decoded_nxt >= tot_sym_r);
  assign out_free = !out_valid_r || out_tready;
  assign push     = pend_v_r && (res_en || cmd.flush);

  // status back to the controller
  assign sts.len_bad     = (in_code_length == '0) ||
                           (in_code_length > htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN));
  assign sts.at_root     = (cur_node_r == '0);
  assign sts.ld_done     = (len_r == '0);
  assign sts.ld_kid_zero = (ld_kid == '0);
  assign sts.store_full  = (next_free_r == htd_pkg::FREE_W'(htd_pkg::NODE_COUNT));
  assign sts.stop        = (cur_node_r == '0) &&
                           !((decoded_r < tot_sym_r) && (bits_r < tot_bits_r));
  assign sts.dc_kid_zero = (dc_kid == '0);
  assign sts.bit_last    = (bit_r == '0);
  assign sts.pend_v      = pend_v_r;
  assign sts.pend_ok     = !pend_v_r || out_free;
  assign sts.out_free    = out_free;

  // walk registers, payload only
  always_ff @(posedge clk) begin
    if (cmd.cap_load) begin
      code_r <= in_code;
      len_r  <= in_code_length;
      sym_r  <= in_symbol;
      walk_r <= '0;
      cur_r  <= root_node;
    end else if (cmd.ld_take) begin
      cur_r  <= rd_r;
      walk_r <= kid_r;
      len_r  <= len_dec;
    end else if (cmd.ld_new) begin
      cur_r  <= '0;
      walk_r <= new_idx;
      len_r  <= len_dec;
    end else if (cmd.cap_dec) begin
      byte_r <= in_data_byte;
      bit_r  <= htd_pkg::BIDX_W'(htd_pkg::BYTE_W - 1);
      cur_r  <= root_node;
    end else if (cmd.dc_load_cur) begin
      cur_r <= rd_r;
    end else if (cmd.dc_step) begin
      if (dc_kid == '0) begin
        cur_r <= root_node;
        bit_r <= bit_r - htd_pkg::BIDX_W'(1);
      end
    end else if (cmd.dc_land) begin
      cur_r <= land_leaf ? root_node : rd_r;
      bit_r <= bit_r - htd_pkg::BIDX_W'(1);
    end
    if (cmd.ld_read || cmd.dc_step) begin
      kid_r <= cmd.ld_read ? ld_kid : dc_kid;
    end
    if (res_en) begin
      pend_sym_r  <= res_sym;
      pend_st_r   <= res_st;
      pend_done_r <= res_done;
    end
    if (push) begin
      out_sym_r  <= pend_sym_r;
      out_st_r   <= pend_st_r;
      out_done_r <= pend_done_r;
      out_last_r <= cmd.flush;
    end
  end

  // tree state, counters, configuration and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_left_r  <= '0;
      root_right_r <= '0;
      cur_node_r   <= '0;
      next_free_r  <= htd_pkg::FREE_W'(1);
      decoded_r    <= '0;
      bits_r       <= '0;
      tot_sym_r    <= '0;
      tot_bits_r   <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        root_left_r  <= '0;
        root_right_r <= '0;
        cur_node_r   <= '0;
        next_free_r  <= htd_pkg::FREE_W'(1);
        decoded_r    <= '0;
        bits_r       <= '0;
      end else begin
        if (cmd.ld_link && (walk_r == '0)) begin
          if (ld_dir) begin
            root_right_r <= new_idx;
          end else begin
            root_left_r <= new_idx;
          end
        end
        if (cmd.ld_new) begin
          next_free_r <= next_free_r + htd_pkg::FREE_W'(1);
        end
        if (cmd.dc_step) begin
          if (bits_r != htd_pkg::BITS_MAX) begin
            bits_r <= bits_r + htd_pkg::BITS_W'(1);
          end
          if (dc_kid == '0) begin
            cur_node_r <= '0;
          end
        end
        if (cmd.dc_land) begin
          decoded_r  <= decoded_nxt;
          cur_node_r <= land_leaf ? '0 : kid_r;
        end
      end
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          htd_pkg::CFG_TOTAL_SYMBOLS: tot_sym_r  <= cfg_data[htd_pkg::CNT_W-1:0];
          htd_pkg::CFG_TOTAL_BITS:    tot_bits_r <= cfg_data[htd_pkg::BITS_W-1:0];
          default: begin
          end
        endcase
      end
      // pending result and output register
      if (res_en) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_status = out_st_r;
  assign out_last   = out_last_r;
  assign out_done   = out_done_r;

  // checks
  `HTDU_ASSERT_IMPL(a_free_bound, clk, rst_n, 1'b1, next_free_r <= htd_pkg::FREE_W'(htd_pkg::NODE_COUNT), "node allocation ran past the store")
  `HTDU_ASSERT_IMPL(a_push_room, clk, rst_n, push, !out_valid_r || out_tready, "result pushed over a waiting result")
  `HTDU_ASSERT_NEXT(a_bits_mono, clk, rst_n, !cmd.clear, bits_r >= $past(bits_r), "bit counter went backward")
  `HTDU_ASSERT_IMPL(a_leaf_not_root, clk, rst_n, cmd.ld_leaf, walk_r != '0, "leaf written at the root")

endmodule

// File: src/huffman_tree_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// code tree builder and bit-serial tree walk decoder
// ----------------------------------------------------------------------------
// One request is worked at a time, and a new one is taken once the previous
// one has handed its last result to the output register. The steps follow
// from the node store, whose read data is registered: a load works each code
// bit in S_LD_WALK and then either S_LD_WAIT (a read of an existing child)
// or S_LD_NEW (a parent update plus a new node write), and a last S_LD_WALK
// marks the leaf. A decode byte works each bit that hits a missing branch in
// S_DC_BIT alone and each bit that reads a child in S_DC_BIT and S_DC_LAND,
// after S_DC_FETCH refetches the current node when a walk is under way, and
// hands over the last result in S_FLUSH; an output stall can hold S_DC_BIT,
// S_DC_LAND and S_FLUSH. A clear is done as it is accepted, and a rejected
// load passes through S_FLUSH. No clearing pass runs after reset:
// the free node count bounds which entries can be reached.
module huffman_tree_decoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // code[31:0], code_length[37:32], symbol[45:38], data_byte[53:46]
  input  logic [55:0]                         in_tdata,
  // req_type[1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_symbol[7:0], done_res[8]
  output logic [15:0]                         out_tdata,
  // status[1:0]
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [htd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [htd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  htd_pkg::cmd_t cmd;
  htd_pkg::sts_t sts;
  logic [htd_pkg::SYM_W-1:0] out_symbol;
  logic                      out_done;

  htd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_req_type (in_tuser),
    .in_tready   (in_tready),
    .cmd         (cmd),
    .sts         (sts)
  );

  htd_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_code        (in_tdata[31:0]),
    .in_code_length (in_tdata[37:32]),
    .in_symbol      (in_tdata[45:38]),
    .in_data_byte   (in_tdata[53:46]),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_tready     (out_tready),
    .out_valid      (out_tvalid),
    .out_symbol     (out_symbol),
    .out_status     (out_tuser),
    .out_last       (out_tlast),
    .out_done       (out_done)
  );

  // result packing
  assign out_tdata = {7'b0, out_done, out_symbol};

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit testbench
// drives load, decode and clear requests and predicts every result from a
// local copy of the code tree, walk position and counters; results are
// compared in order, field by field, under random source and sink idling
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [htd_pkg::BITS_W-1:0] BITS_LIMIT_TOP = 35'h7_FFFF_FFF8;
  localparam logic [1:0]                 REQ_UNKNOWN    = 2'd3;

  // one decoder result
  typedef struct packed {
    logic [htd_pkg::SYM_W-1:0] sym;
    logic [1:0]                status;
    logic                      last;
    logic                      done;
  } huff_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [55:0]                    in_tdata;
  logic [1:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [15:0]                    out_tdata;
  logic [1:0]                     out_tuser;
  logic                           out_tlast;
  logic                           cfg_we;
  logic [htd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [htd_pkg::CFG_DATA_W-1:0] cfg_data;

  // predicted tree, walk and counters
  bit                        nd_leaf [htd_pkg::NODE_COUNT];
  logic [htd_pkg::SYM_W-1:0] nd_sym  [htd_pkg::NODE_COUNT];
  int unsigned               nd_kid  [htd_pkg::NODE_COUNT][2];
  int unsigned               walk_node;
  int unsigned               free_node;
  logic [htd_pkg::CNT_W-1:0]  sym_count;
  logic [htd_pkg::CNT_W-1:0]  sym_limit;
  logic [htd_pkg::BITS_W-1:0] bit_count;
  logic [htd_pkg::BITS_W-1:0] bit_limit;

  huff_result_t step_q[$];
  huff_result_t decoded_q[$];

  int errors    = 0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_left = 0;

  huffman_tree_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_tree();
    for (int n = 0; n < htd_pkg::NODE_COUNT; n++) begin
      nd_leaf[n]   = 1'b0;
      nd_sym[n]    = '0;
      nd_kid[n][0] = 0;
      nd_kid[n][1] = 0;
    end
    walk_node = 0;
    free_node = 1;
    sym_count = '0;
    bit_count = '0;
  endtask

  task automatic stage_result(input logic [htd_pkg::SYM_W-1:0] sym, input logic [1:0] status);
    huff_result_t r;
    r.sym    = sym;
    r.status = status;
    r.last   = 1'b0;
    r.done   = (sym_count >= sym_limit);
    step_q.push_back(r);
  endtask

  task automatic predict_request(input logic [1:0] kind, input logic [55:0] data);
    logic [htd_pkg::CODE_W-1:0] code;
    int unsigned       len;
    int unsigned       node;
    int unsigned       kid;
    int unsigned       dir;
    int unsigned       i;
    int                b;
    logic              ok;
    logic              stop;
    huff_result_t      r;
    code = data[31:0];
    len  = 32'(data[37:32]);
    case (kind)
      htd_pkg::REQ_LOAD: begin
        if (len == 0 || len > htd_pkg::MAX_CODE_LEN) begin
          stage_result('0, htd_pkg::ST_BADLEN);
        end else begin
          node = 0;
          ok   = 1'b1;
          i    = len;
          // walk the code from its first bit, growing missing nodes
          while (ok && i > 0) begin
            dir = 32'(code[i-1]);
            kid = nd_kid[node][dir];
            if (kid == 0) begin
              if (free_node >= htd_pkg::NODE_COUNT) begin
                stage_result('0, htd_pkg::ST_FULL);
                ok = 1'b0;
              end else begin
                kid = free_node;
                free_node++;
                nd_leaf[kid]     = 1'b0;
                nd_sym[kid]      = '0;
                nd_kid[kid][0]   = 0;
                nd_kid[kid][1]   = 0;
                nd_kid[node][dir] = kid;
              end
            end
            node = kid;
            i--;
          end
          if (ok) begin
            nd_leaf[node] = 1'b1;
            nd_sym[node]  = data[45:38];
          end
        end
      end
      htd_pkg::REQ_DECODE: begin
        stop = 1'b0;
        // byte bits from the top down, stop test only at the root
        for (b = 7; b >= 0; b--) begin
          if (!stop) begin
            if (walk_node == 0 && !(sym_count < sym_limit && bit_count < bit_limit)) begin
              stop = 1'b1;
            end else begin
              dir = 32'(data[46+b]);
              if (bit_count != htd_pkg::BITS_MAX) bit_count++;
              kid = nd_kid[walk_node][dir];
              if (kid == 0) begin
                walk_node = 0;
                stage_result('0, htd_pkg::ST_MISSING);
              end else begin
                walk_node = kid;
                if (nd_leaf[kid]) begin
                  sym_count++;
                  walk_node = 0;
                  stage_result(nd_sym[kid], htd_pkg::ST_SYMBOL);
                end
              end
            end
          end
        end
      end
      htd_pkg::REQ_CLEAR: clear_tree();
      default: ;
    endcase
    // the final result of the request carries last
    while (step_q.size() > 0) begin
      r      = step_q.pop_front();
      r.last = (step_q.size() == 0);
      decoded_q.push_back(r);
    end
  endtask

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
  end

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    huff_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: sym %h status %0d last %b done %b", $time,
                 out_tdata[7:0], out_tuser, out_tlast, out_tdata[8]);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata[7:0] !== want.sym || out_tuser !== want.status ||
            out_tlast !== want.last || out_tdata[8] !== want.done) begin
          $display("%0t: mismatch: expected sym %h status %0d last %b done %b", $time,
                   want.sym, want.status, want.last, want.done);
          $display("%0t:           actual   sym %h status %0d last %b done %b", $time,
                   out_tdata[7:0], out_tuser, out_tlast, out_tdata[8]);
          errors++;
        end
      end
    end
  end

  // sink: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------ drivers

  function automatic logic [55:0] pack_req(input logic [htd_pkg::CODE_W-1:0] code,
                                           input logic [htd_pkg::LEN_W-1:0] len,
                                           input logic [htd_pkg::SYM_W-1:0] sym,
                                           input logic [htd_pkg::BYTE_W-1:0] data_byte);
    return {2'b00, data_byte, sym, len, code};
  endfunction

  function automatic logic [55:0] noise_fields();
    return pack_req($urandom, htd_pkg::LEN_W'($urandom_range(63)),
                    htd_pkg::SYM_W'($urandom_range(255)),
                    htd_pkg::BYTE_W'($urandom_range(255)));
  endfunction

  // valid stays high between back-to-back requests
  task automatic send_req(input logic [1:0] kind, input logic [55:0] data);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_decode(input logic [htd_pkg::BYTE_W-1:0] data_byte);
    send_req(htd_pkg::REQ_DECODE, pack_req($urandom, htd_pkg::LEN_W'($urandom_range(63)),
                                           htd_pkg::SYM_W'($urandom_range(255)), data_byte));
  endtask

  task automatic send_load(input logic [htd_pkg::CODE_W-1:0] code,
                           input logic [htd_pkg::LEN_W-1:0] len,
                           input logic [htd_pkg::SYM_W-1:0] sym);
    send_req(htd_pkg::REQ_LOAD,
             pack_req(code, len, sym, htd_pkg::BYTE_W'($urandom_range(255))));
  endtask

  // drain all results, then allow a long load to finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_limits(input logic [htd_pkg::CNT_W-1:0] syms,
                            input logic [htd_pkg::BITS_W-1:0] bits);
    cfg_we    <= 1'b1;
    cfg_index <= htd_pkg::CFG_TOTAL_SYMBOLS;
    cfg_data  <= htd_pkg::CFG_DATA_W'(syms);
    @(posedge clk);
    sym_limit = syms;
    cfg_index <= htd_pkg::CFG_TOTAL_BITS;
    cfg_data  <= bits;
    @(posedge clk);
    bit_limit = bits;
    cfg_we <= 1'b0;
  endtask

  // complete prefix code built by random leaf splits, loaded with junk above the length
  task automatic load_code_set(input int unsigned max_len, output int loads);
    int unsigned cs_code[$];
    int unsigned cs_len[$];
    int unsigned n;
    int unsigned k;
    logic [htd_pkg::CODE_W-1:0] code;
    cs_code.push_back(0);
    cs_len.push_back(0);
    n = $urandom_range(2, 12);
    // short codes cannot hold many symbols
    if (max_len < 4 && n > (1 << max_len)) n = 1 << max_len;
    while (cs_code.size() < n) begin
      k = $urandom_range(cs_code.size() - 1);
      if (cs_len[k] < max_len) begin
        cs_code.push_back((cs_code[k] << 1) | 1);
        cs_len.push_back(cs_len[k] + 1);
        cs_code[k] = cs_code[k] << 1;
        cs_len[k]  = cs_len[k] + 1;
      end
    end
    for (k = 0; k < cs_code.size(); k++) begin
      code = (htd_pkg::CODE_W'($urandom) << cs_len[k]) | htd_pkg::CODE_W'(cs_code[k]);
      send_load(code, htd_pkg::LEN_W'(cs_len[k]), htd_pkg::SYM_W'($urandom_range(255)));
    end
    loads = cs_code.size();
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    wait_idle();
    set_limits(32'hFFFF_FFFF, BITS_LIMIT_TOP);
    // bad lengths: zero and above the maximum
    send_load(32'h0000_0000, 6'd0, 8'h10);
    send_load(32'h1234_5678, 6'd33, 8'h11);
    send_load(32'hFFFF_FFFF, 6'd63, 8'h12);
    // small tree plus one longest code
    send_load(32'h0000_0000, 6'd1, 8'h41);
    send_load(32'hFFFF_FFFE, 6'd2, 8'h42);
    send_load(32'hFFFF_FFFF, 6'd32, 8'hFF);
    send_decode(8'h00);
    send_decode(8'h80);
    send_decode(8'hFF);
    // load while a walk is under way
    send_load(32'h0000_0006, 6'd3, 8'h43);
    send_decode(8'hFF);
    send_decode(8'hFF);
    send_decode(8'hFF);
    send_decode(8'hC0);
    // load through an existing leaf, then reload paths
    send_load(32'h0000_0000, 6'd2, 8'h44);
    send_decode(8'h00);
    send_load(32'h0000_0000, 6'd1, 8'h45);
    send_load(32'h0000_0001, 6'd1, 8'h46);
    send_decode(8'h5A);
    // missing branches after a clear
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
    send_load(32'h0000_0001, 6'd2, 8'h11);
    send_decode(8'h7F);
    send_decode(8'h00);
    // unknown request is dropped
    send_req(REQ_UNKNOWN, noise_fields());
    send_decode(8'h40);
  endtask

  task automatic test_stop_limits();
    // symbol limit reached mid byte
    wait_idle();
    set_limits(32'd3, BITS_LIMIT_TOP);
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
    send_load(32'h0, 6'd1, 8'hA0);
    send_load(32'h1, 6'd1, 8'hA1);
    send_decode(8'h55);
    send_decode(8'h55);
    // bit limit reached
    wait_idle();
    set_limits(32'hFFFF_FFFF, 35'd10);
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
    send_load(32'h0, 6'd1, 8'hB0);
    send_decode(8'h00);
    send_decode(8'h00);
    // a walk under way runs past the bit limit
    wait_idle();
    set_limits(32'hFFFF_FFFF, 35'd3);
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
    send_load(32'h0, 6'd6, 8'hB7);
    send_decode(8'h00);
    send_decode(8'h00);
    // both limits zero: nothing decodes, errors report done
    wait_idle();
    set_limits(32'd0, 35'd0);
    send_decode(8'hFF);
    send_load(32'h0, 6'd0, 8'h00);
    wait_idle();
    set_limits(32'hFFFF_FFFF, 35'h7_FFFF_FFFF);
    send_decode(8'h00);
  endtask

  task automatic test_store_full();
    wait_idle();
    set_limits(32'hFFFF_FFFF, BITS_LIMIT_TOP);
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
    repeat (22) send_load($urandom, 6'd32, htd_pkg::SYM_W'($urandom_range(255)));
    repeat (4) send_decode(htd_pkg::BYTE_W'($urandom_range(255)));
    send_load(32'h0, 6'd1, 8'h5C);
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
  endtask

  task automatic test_backpressure();
    int loads;
    wait_idle();
    set_limits(32'hFFFF_FFFF, BITS_LIMIT_TOP);
    send_req(htd_pkg::REQ_CLEAR, noise_fields());
    send_load(32'h0, 6'd1, 8'hC0);
    send_load(32'h1, 6'd1, 8'hC1);
    load_code_set(1, loads);
    // sink holds off while decode requests keep coming
    hold_left = 400;
    repeat (12) send_decode(htd_pkg::BYTE_W'($urandom_range(255)));
  endtask

  task automatic test_random(input int target);
    int sent;
    int loads;
    int k;
    logic [1:0] kind;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(2) == 0) begin
        wait_idle();
        case ($urandom_range(3))
          0:       set_limits(htd_pkg::CNT_W'($urandom_range(1, 40)), BITS_LIMIT_TOP);
          1:       set_limits(32'hFFFF_FFFF, htd_pkg::BITS_W'($urandom_range(8, 300)));
          2:       set_limits($urandom, {3'($urandom_range(7)), 32'($urandom)});
          default: set_limits(32'hFFFF_FFFF, BITS_LIMIT_TOP);
        endcase
      end
      send_req(htd_pkg::REQ_CLEAR, noise_fields());
      load_code_set($urandom_range(1, 10), loads);
      sent += loads + 1;
      k = $urandom_range(3, 10);
      repeat (k) send_decode(htd_pkg::BYTE_W'($urandom_range(255)));
      sent += k;
      // noise: any request kind with random fields
      k = $urandom_range(0, 3);
      repeat (k) begin
        kind = 2'($urandom_range(3));
        send_req(kind, noise_fields());
        if (kind != REQ_UNKNOWN) sent++;
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= htd_pkg::REQ_LOAD;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= htd_pkg::CFG_TOTAL_SYMBOLS;
    cfg_data   <= '0;
    clear_tree();
    sym_limit = '0;
    bit_limit = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 13;
    stall_pct = 48;
    test_directed();
    test_stop_limits();
    test_random(70);

    gap_pct   = 48;
    stall_pct = 13;
    test_store_full();
    test_random(70);

    gap_pct   = 0;
    stall_pct = 0;
    test_backpressure();
    test_random(70);

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/htd_pkg.sv
src/htd_ctrl.sv
src/htd_datapath.sv
src/huffman_tree_decoder_unit.sv
test/testbench.sv
